>>> hw/rtl/vcam_pkg.sv
// shared types and constants of the comb artifact marker
package vcam_pkg;

	localparam int FW_W       = 12;
	localparam int FH_W       = 16;
	localparam int MARGIN_W   = 8;
	localparam int CNT_W      = 10;
	localparam int LUMA_W     = 8;
	localparam int EPOCH_W    = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [FW_W-1:0]     FRAME_WIDTH_RST   = 12'd2048;
	localparam logic [FH_W-1:0]     FRAME_HEIGHT_RST  = 16'd1080;
	localparam logic [MARGIN_W-1:0] MARGIN_RST        = 8'd5;
	localparam logic [CNT_W-1:0]    RUN_LIMIT_RST     = 10'd1000;
	localparam logic [CNT_W-1:0]    TRIGGER_LEVEL_RST = 10'd100;

	// zebra stripe levels and the phase bit that picks between them
	localparam logic [LUMA_W-1:0] STRIPE_HI  = 8'd235;
	localparam logic [LUMA_W-1:0] STRIPE_LO  = 8'd16;
	localparam int                STRIPE_BIT = 2;

	// first processed row and border rows
	localparam logic [FH_W-1:0] FIRST_JUDGED_ROW = 16'd3;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CNT_W = 4;
	localparam int FIFO_SLACK = 4;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_FRAME_WIDTH   = 3'd0,
		CFG_FRAME_HEIGHT  = 3'd1,
		CFG_MARGIN        = 3'd2,
		CFG_RUN_LIMIT     = 3'd3,
		CFG_TRIGGER_LEVEL = 3'd4
	} cfg_idx_t;

	// per item control word from the raster tracker to the judge stage
	typedef struct packed {
		logic [LUMA_W-1:0]  luma;
		logic               frame_start;
		logic               prev_row;
		logic               process;
		logic               last_row;
		logic               last_col;
		logic [2:0]         stripe;
		logic [EPOCH_W-1:0] epoch;
	} item_ctl_t;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		logic              marked;
		logic              last;
		logic              done;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

>>> hw/rtl/vcam_raster.sv
// raster position, row classification and frame numbering
module vcam_raster import vcam_pkg::*; #(
	parameter int MAX_LINE = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [LUMA_W-1:0]           luma,
	input  logic [FW_W-1:0]             frame_width,
	input  logic [FH_W-1:0]             frame_height,
	output logic [$clog2(MAX_LINE)-1:0] col,
	output item_ctl_t                   ctl
);

	localparam int CW = $clog2(MAX_LINE);
	localparam int WW = CW + 1;
	localparam int LW = (WW > FW_W) ? WW : FW_W;

	logic [CW-1:0]      col_q, col_n;
	logic [FH_W-1:0]    row_q, row_n;
	logic [EPOCH_W-1:0] epoch_q, epoch_eff;
	logic [LW-1:0]      fw_ext;
	logic [WW-1:0]      eff_w, c_inc;
	logic [FH_W-1:0]    eff_h, r, j;
	logic [FH_W:0]      r_pre, r_inc;
	logic               wrap_pre;
	logic [CW-1:0]      c;

	always_comb begin
		fw_ext = LW'(frame_width);
		if (frame_width == '0) begin
			eff_w = WW'(1);
		end else if (fw_ext > LW'(MAX_LINE)) begin
			eff_w = WW'(MAX_LINE);
		end else begin
			eff_w = WW'(fw_ext);
		end
		eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;

		// geometry may have shrunk since the last item
		wrap_pre = {1'b0, col_q} >= eff_w;
		c        = wrap_pre ? '0 : col_q;
		r_pre    = wrap_pre ? ({1'b0, row_q} + (FH_W+1)'(1)) : {1'b0, row_q};
		r        = (r_pre >= {1'b0, eff_h}) ? '0 : r_pre[FH_W-1:0];
		j        = r - FH_W'(1);

		ctl.luma        = luma;
		ctl.frame_start = (r == '0) && (c == '0);
		ctl.prev_row    = (r != '0);
		ctl.process     = (r >= FIRST_JUDGED_ROW) &&
		                  (({1'b0, r} + (FH_W+1)'(1)) < {1'b0, eff_h});
		ctl.last_row    = (r == eff_h - FH_W'(1));
		ctl.last_col    = ({1'b0, c} == eff_w - WW'(1));
		epoch_eff       = ctl.frame_start ? (epoch_q + EPOCH_W'(1)) : epoch_q;
		ctl.epoch       = epoch_eff;
		ctl.stripe      = c[2:0] + j[2:0] + epoch_eff[2:0];
		col             = c;

		// advance
		c_inc = {1'b0, c} + WW'(1);
		r_inc = {1'b0, r} + (FH_W+1)'(1);
		if (c_inc >= eff_w) begin
			col_n = '0;
			row_n = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[FH_W-1:0];
		end else begin
			col_n = c_inc[CW-1:0];
			row_n = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			epoch_q <= '0;
		end else if (accept) begin
			col_q   <= col_n;
			row_q   <= row_n;
			epoch_q <= epoch_eff;
		end
	end

endmodule

>>> hw/rtl/vcam_judge.sv
// row and run count memories, comb test and result forming
module vcam_judge import vcam_pkg::*; #(
	parameter int MAX_LINE = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [$clog2(MAX_LINE)-1:0] col,
	input  item_ctl_t                   ctl,
	input  logic [MARGIN_W-1:0]         margin,
	input  logic [CNT_W-1:0]            run_limit,
	input  logic [CNT_W-1:0]            trigger_level,
	output logic                        busy,
	output push_t                       push
);

	localparam int CW    = $clog2(MAX_LINE);
	localparam int ROW_W = 2 * LUMA_W;
	localparam int TAG_W = EPOCH_W + CNT_W;

	logic [ROW_W-1:0] row_mem [MAX_LINE];
	logic [TAG_W-1:0] cnt_mem [MAX_LINE];

	logic [ROW_W-1:0]  row_rd_q, rfw_data_q, row_word, row_wr;
	logic [TAG_W-1:0]  cnt_rd_q, cfw_data_q, cnt_word;
	logic [CW-1:0]     col_s1, rfw_addr_q, cfw_addr_q, clr_q;
	item_ctl_t         ctl_s1;
	logic              valid_s1, rfw_v_q, cfw_v_q, busy_q;
	logic [CNT_W-1:0]  left_q, left_v, col_val, cnt;
	logic [CNT_W+1:0]  sum;
	logic [LUMA_W-1:0] mid, up, x, lo, hi, stripe_val;
	logic [LUMA_W:0]   mid_x, lo_x, hi_x, mg_x;
	logic              combed, hit;
	result_t           res_a, res_b;

	assign busy = busy_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			row_rd_q <= row_mem[col];
			cnt_rd_q <= cnt_mem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			row_mem[col_s1] <= row_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			cnt_mem[clr_q] <= '0;
		end else if (valid_s1 && ctl_s1.process) begin
			cnt_mem[col_s1] <= {ctl_s1.epoch, cnt};
		end
	end

	always_comb begin
		// a write at the edge of this item's read is not yet in the read data
		row_word = (rfw_v_q && (rfw_addr_q == col_s1)) ? rfw_data_q : row_rd_q;
		cnt_word = (cfw_v_q && (cfw_addr_q == col_s1)) ? cfw_data_q : cnt_rd_q;
		mid      = row_word[LUMA_W-1:0];
		up       = row_word[ROW_W-1:LUMA_W];
		x        = ctl_s1.luma;
		row_wr   = {mid, x};

		// a count from an earlier frame reads as zero
		col_val = (cnt_word[TAG_W-1:CNT_W] == ctl_s1.epoch) ? cnt_word[CNT_W-1:0] : '0;

		lo     = (up < x) ? up : x;
		hi     = (up < x) ? x : up;
		mid_x  = {1'b0, mid};
		lo_x   = {1'b0, lo};
		hi_x   = {1'b0, hi};
		mg_x   = {1'b0, margin};
		combed = ((mid_x + mg_x) < lo_x) || (mid_x > (hi_x + mg_x));

		left_v = (col_s1 != '0) ? left_q : '0;
		sum    = (CNT_W+2)'(col_val) + (CNT_W+2)'(left_v) + (CNT_W+2)'(1);
		if (!combed) begin
			cnt = '0;
		end else if (sum > (CNT_W+2)'(run_limit)) begin
			cnt = run_limit;
		end else begin
			cnt = sum[CNT_W-1:0];
		end
		hit        = cnt > trigger_level;
		stripe_val = ctl_s1.stripe[STRIPE_BIT] ? STRIPE_HI : STRIPE_LO;

		res_a.last = 1'b0;
		res_a.done = 1'b0;
		if (!ctl_s1.process) begin
			res_a.luma   = mid >> 1;
			res_a.marked = 1'b0;
		end else if (hit) begin
			res_a.luma   = stripe_val;
			res_a.marked = 1'b1;
		end else begin
			res_a.luma   = mid;
			res_a.marked = 1'b0;
		end
		res_b.luma   = x >> 1;
		res_b.marked = 1'b0;
		res_b.last   = 1'b1;
		res_b.done   = ctl_s1.last_col;

		if (ctl_s1.prev_row) begin
			push.v0      = valid_s1;
			push.r0      = res_a;
			push.r0.last = !ctl_s1.last_row;
			push.v1      = valid_s1 && ctl_s1.last_row;
			push.r1      = res_b;
		end else begin
			push.v0 = valid_s1 && ctl_s1.last_row;
			push.r0 = res_b;
			push.v1 = 1'b0;
			push.r1 = res_b;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col;
			ctl_s1 <= ctl;
		end
		rfw_addr_q <= col_s1;
		rfw_data_q <= row_wr;
		cfw_addr_q <= col_s1;
		cfw_data_q <= {ctl_s1.epoch, cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rfw_v_q  <= 1'b0;
			cfw_v_q  <= 1'b0;
			left_q   <= '0;
			busy_q   <= 1'b1;
			clr_q    <= '0;
		end else begin
			valid_s1 <= accept;
			rfw_v_q  <= valid_s1;
			cfw_v_q  <= valid_s1 && ctl_s1.process;
			if (valid_s1) begin
				if (ctl_s1.frame_start) begin
					left_q <= '0;
				end else if (ctl_s1.process) begin
					left_q <= cnt;
				end
			end
			if (busy_q) begin
				clr_q <= clr_q + CW'(1);
				if (clr_q == CW'(MAX_LINE - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> hw/rtl/vcam_out_fifo.sv
// result queue in front of the master port
module vcam_out_fifo import vcam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop_ready,
	output logic    out_valid,
	output result_t out_data,
	output logic    space_ok
);

	result_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]    head_q, tail_q;
	logic [FIFO_CNT_W-1:0] count_q, n_push;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[head_q];
	assign pop       = out_valid && pop_ready;
	assign n_push    = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);
	assign space_ok  = count_q <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_SLACK);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			slot_q[tail_q] <= push.r0;
		end
		if (push.v1) begin
			slot_q[tail_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + n_push[FIFO_AW-1:0];
			head_q  <= head_q + FIFO_AW'(pop);
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

>>> hw/rtl/video_comb_artifact_marker_core.sv
// top level of the comb artifact marker
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------------------
//  s_axis   | in  | tvalid / tready      | tdata[7:0] luma_in
//  m_axis   | out | tvalid / tready      | tdata[7:0] luma_out, tlast last_of_run,
//           |     |                      | tuser[0] marked, tuser[1] frame_done
//  cfg      | in  | cfg_we (no wait)     | cfg_addr register index, cfg_wdata value
//
// one item per clock while s_axis_tready is high; an item's first result reaches m_axis
// after the row/count memory read and then the judge stage into the result queue
// pixels leave one row late: the row memory holds the two previous rows per column
// after reset the run count memory is swept to zero, one entry a cycle, over all MAX_LINE
// entries (2048 by default) with s_axis_tready low
// the result queue holds 8 items; s_axis_tready drops once more than 4 are waiting
module video_comb_artifact_marker_core import vcam_pkg::*; #(
	parameter int MAX_LINE = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [LUMA_W-1:0]     s_axis_tdata,   // [7:0] luma_in
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [LUMA_W-1:0]     m_axis_tdata,   // [7:0] luma_out
	output logic                  m_axis_tlast,
	output logic [1:0]            m_axis_tuser,   // [0] marked, [1] frame_done
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_LINE);

	logic [FW_W-1:0]     frame_width_q;
	logic [FH_W-1:0]     frame_height_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [CNT_W-1:0]    run_limit_q;
	logic [CNT_W-1:0]    trigger_level_q;

	logic          accept;
	logic [CW-1:0] col;
	item_ctl_t     ctl;
	logic          clear_busy;
	push_t         push;
	logic          space_ok;
	result_t       out_data;

	// configuration registers: the user writes them only while the stream is quiet; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			margin_q        <= MARGIN_RST;
			run_limit_q     <= RUN_LIMIT_RST;
			trigger_level_q <= TRIGGER_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_wdata[FW_W-1:0];
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_wdata[FH_W-1:0];
				CFG_MARGIN:        margin_q        <= cfg_wdata[MARGIN_W-1:0];
				CFG_RUN_LIMIT:     run_limit_q     <= cfg_wdata[CNT_W-1:0];
				CFG_TRIGGER_LEVEL: trigger_level_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input side only waits for the reset sweep and for queue room
	assign s_axis_tready = !clear_busy && space_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// stage 0: where the pixel sits in the frame, what its results will be
	vcam_raster #(
		.MAX_LINE (MAX_LINE)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.luma         (s_axis_tdata),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.col          (col),
		.ctl          (ctl)
	);

	// stage 1: row and count read-modify-write, comb test, stripe substitution
	vcam_judge #(
		.MAX_LINE (MAX_LINE)
	) u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.col           (col),
		.ctl           (ctl),
		.margin        (margin_q),
		.run_limit     (run_limit_q),
		.trigger_level (trigger_level_q),
		.busy          (clear_busy),
		.push          (push)
	);

	// zero, one or two results per item go into the queue
	vcam_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (out_data),
		.space_ok  (space_ok)
	);

	assign m_axis_tdata    = out_data.luma;
	assign m_axis_tlast    = out_data.last;
	assign m_axis_tuser[0] = out_data.marked;
	assign m_axis_tuser[1] = out_data.done;

	// the end of a frame is always the final result of its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("frame end without last_of_run");

	// a marked item carries one of the two stripe levels
	a_marked_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata == STRIPE_HI) || (m_axis_tdata == STRIPE_LO))
		else $error("marked item with a non-stripe level");

	// a second result never comes without a first
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result pushed alone");

	// nothing enters the judge stage while the count memory is being swept
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |=> !push.v0)
		else $error("result produced during count sweep");

endmodule
